// ===== hw/rtl/r2q_pkg.sv =====
package r2q_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	localparam int DIF_W   = DATA_WIDTH + 1;
	localparam int TRACE_W = DATA_WIDTH + 2;
	localparam int ARG_W   = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
	localparam int RAD_W   = ARG_W - 1 + FRAC_BITS;
	localparam int ROOT_W  = (RAD_W + 1) / 2;
	localparam int RADP_W  = 2 * ROOT_W;
	localparam int REM_W   = ROOT_W + 3;
	localparam int NUM_W   = DATA_WIDTH + FRAC_BITS + 2;
	localparam int DEN_W   = ROOT_W + 1;
	localparam int QUO_W   = DATA_WIDTH;
	localparam int CMP_W   = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;
	localparam int MAG_W   = ((QUO_W > ROOT_W) ? QUO_W : ROOT_W) + 1;
	localparam int LATENCY = ROOT_W + QUO_W + 5;

	localparam logic [ARG_W-1:0] ONE_ARG = {{(ARG_W-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [MAG_W-1:0] MAG_NEG = {{(MAG_W-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
	localparam logic [MAG_W-1:0] MAG_POS = MAG_NEG - {{(MAG_W-1){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		SLOT_W = 2'd0,
		SLOT_X = 2'd1,
		SLOT_Y = 2'd2,
		SLOT_Z = 2'd3
	} r2q_slot_t;

	typedef enum logic [1:0] {
		AXIS_0 = 2'd0,
		AXIS_1 = 2'd1,
		AXIS_2 = 2'd2
	} r2q_axis_t;

	typedef struct packed {
		logic [3:0][DIF_W-1:0] d;
		r2q_slot_t slot;
		logic flag;
	} r2q_side_t;

	typedef struct packed {
		r2q_slot_t slot;
		logic flag;
		logic zero;
		logic [ROOT_W-1:0] hq;
		logic [3:0] neg;
	} r2q_meta_t;

endpackage

// ===== hw/rtl/r2q_front.sv =====
module r2q_front import r2q_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic valid_s2,
	output logic [RADP_W-1:0] rad_s2,
	output r2q_side_t side_s2
);

	logic valid_s1;
	logic signed [DATA_WIDTH-1:0] m00_s1, m01_s1, m02_s1, m10_s1, m11_s1;
	logic signed [DATA_WIDTH-1:0] m12_s1, m20_s1, m21_s1, m22_s1;
	logic signed [TRACE_W-1:0] trace, trace_s1;
	logic tpos, tpos_s1;
	logic signed [DATA_WIDTH-1:0] diag_max;
	r2q_axis_t isel, isel_s1;

	assign trace = TRACE_W'(m00) + TRACE_W'(m11) + TRACE_W'(m22);
	assign tpos = !trace[TRACE_W-1] && (|trace);

	// later diagonal wins only when strictly larger
	always_comb begin
		isel = AXIS_0;
		diag_max = m00;
		if (m11 > m00) begin
			isel = AXIS_1;
			diag_max = m11;
		end
		if (m22 > diag_max)
			isel = AXIS_2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		m00_s1 <= m00; m01_s1 <= m01; m02_s1 <= m02;
		m10_s1 <= m10; m11_s1 <= m11; m12_s1 <= m12;
		m20_s1 <= m20; m21_s1 <= m21; m22_s1 <= m22;
		trace_s1 <= trace;
		tpos_s1 <= tpos;
		isel_s1 <= isel;
	end

	logic signed [DIF_W-1:0] e01, e02, e10, e12, e20, e21;
	logic signed [DIF_W-1:0] d21m12, d02m20, d10m01, s10p01, s20p02, s21p12;
	logic signed [DATA_WIDTH-1:0] aii, ajj, akk;
	logic [ARG_W-1:0] arg;
	logic neg_arg;
	r2q_side_t side;

	assign e01 = DIF_W'(m01_s1);
	assign e02 = DIF_W'(m02_s1);
	assign e10 = DIF_W'(m10_s1);
	assign e12 = DIF_W'(m12_s1);
	assign e20 = DIF_W'(m20_s1);
	assign e21 = DIF_W'(m21_s1);
	assign d21m12 = e21 - e12;
	assign d02m20 = e02 - e20;
	assign d10m01 = e10 - e01;
	assign s10p01 = e10 + e01;
	assign s20p02 = e20 + e02;
	assign s21p12 = e21 + e12;

	always_comb begin
		case (isel_s1)
			AXIS_1: begin
				aii = m11_s1; ajj = m22_s1; akk = m00_s1;
			end
			AXIS_2: begin
				aii = m22_s1; ajj = m00_s1; akk = m11_s1;
			end
			default: begin
				aii = m00_s1; ajj = m11_s1; akk = m22_s1;
			end
		endcase
		side.d = '0;
		if (tpos_s1) begin
			arg = ARG_W'(trace_s1) + ONE_ARG;
			side.slot = SLOT_W;
			side.d[1] = d21m12;
			side.d[2] = d02m20;
			side.d[3] = d10m01;
		end else begin
			arg = ARG_W'(aii) - (ARG_W'(ajj) + ARG_W'(akk)) + ONE_ARG;
			case (isel_s1)
				AXIS_1: begin
					side.slot = SLOT_Y;
					side.d[0] = d02m20;
					side.d[3] = s21p12;
					side.d[1] = s10p01;
				end
				AXIS_2: begin
					side.slot = SLOT_Z;
					side.d[0] = d10m01;
					side.d[1] = s20p02;
					side.d[2] = s21p12;
				end
				default: begin
					side.slot = SLOT_X;
					side.d[0] = d21m12;
					side.d[2] = s10p01;
					side.d[3] = s20p02;
				end
			endcase
		end
		neg_arg = arg[ARG_W-1];
		side.flag = neg_arg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		rad_s2 <= neg_arg ? '0 : (RADP_W'(arg[ARG_W-2:0]) << FRAC_BITS);
		side_s2 <= side;
	end

endmodule

// ===== hw/rtl/r2q_sqrt.sv =====
module r2q_sqrt import r2q_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [RADP_W-1:0] rad,
	input  r2q_side_t side_in,
	output logic out_valid,
	output logic [ROOT_W-1:0] root,
	output r2q_side_t side_out
);

	// one result bit per stage, restoring digit recurrence
	logic vld_s [1:ROOT_W];
	logic [REM_W-1:0] rem_s [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic [RADP_W-1:0] rad_s [1:ROOT_W];
	r2q_side_t side_s [1:ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic p_vld;
		logic [REM_W-1:0] p_rem, cur, trial, diff;
		logic [ROOT_W-1:0] p_root;
		logic [RADP_W-1:0] p_rad;
		r2q_side_t p_side;
		logic ge;

		if (k == 0) begin : g_first
			assign p_vld = in_valid;
			assign p_rem = '0;
			assign p_root = '0;
			assign p_rad = rad;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld = vld_s[k];
			assign p_rem = rem_s[k];
			assign p_root = root_s[k];
			assign p_rad = rad_s[k];
			assign p_side = side_s[k];
		end

		assign cur = {p_rem[REM_W-3:0], p_rad[RADP_W-1 -: 2]};
		assign trial = REM_W'({p_root, 2'b01});
		assign ge = cur >= trial;
		assign diff = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k+1] <= 1'b0;
			else
				vld_s[k+1] <= p_vld;
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff : cur;
			root_s[k+1] <= {p_root[ROOT_W-2:0], ge};
			rad_s[k+1] <= p_rad << 2;
			side_s[k+1] <= p_side;
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root = root_s[ROOT_W];
	assign side_out = side_s[ROOT_W];

endmodule

// ===== hw/rtl/r2q_div.sv =====
module r2q_div import r2q_pkg::*; (
	input  logic clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic ovf
);

	// first stage checks that the quotient fits, then one bit per stage
	logic [NUM_W-1:0] rem_s [0:QUO_W];
	logic [DEN_W-1:0] den_s [0:QUO_W];
	logic [QUO_W-1:0] quo_s [0:QUO_W];
	logic ovf_s [0:QUO_W];

	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= CMP_W'(num) >= (CMP_W'(den) << QUO_W);
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [CMP_W-1:0] dsh;
		logic ge;

		assign dsh = CMP_W'(den_s[k]) << (QUO_W - 1 - k);
		assign ge = CMP_W'(rem_s[k]) >= dsh;

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? (rem_s[k] - dsh[NUM_W-1:0]) : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign quo = quo_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule

// ===== hw/rtl/rotation_matrix_to_quaternion_top.sv =====
// Rotation matrix to quaternion, Q2.14 in and out. A new request may be started in
// every cycle and busy stays low; the receiver cannot stall. Each request gives one
// result with done high for one cycle, after passing through two front stages, one
// stage per root bit of the square-root pipeline, one setup stage, one range-check stage
// plus one stage per quotient bit of the divider lanes, and the output register.
module rotation_matrix_to_quaternion_top import r2q_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [DATA_WIDTH-1:0] m00,
	input  logic signed [DATA_WIDTH-1:0] m01,
	input  logic signed [DATA_WIDTH-1:0] m02,
	input  logic signed [DATA_WIDTH-1:0] m10,
	input  logic signed [DATA_WIDTH-1:0] m11,
	input  logic signed [DATA_WIDTH-1:0] m12,
	input  logic signed [DATA_WIDTH-1:0] m20,
	input  logic signed [DATA_WIDTH-1:0] m21,
	input  logic signed [DATA_WIDTH-1:0] m22,
	output logic done,
	output logic signed [DATA_WIDTH-1:0] qw,
	output logic signed [DATA_WIDTH-1:0] qx,
	output logic signed [DATA_WIDTH-1:0] qy,
	output logic signed [DATA_WIDTH-1:0] qz,
	output logic clamped
);

	logic fr_valid;
	logic [RADP_W-1:0] fr_rad;
	r2q_side_t fr_side;

	assign busy = 1'b0;

	r2q_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.m00(m00), .m01(m01), .m02(m02),
		.m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.valid_s2(fr_valid), .rad_s2(fr_rad), .side_s2(fr_side)
	);

	logic sq_valid;
	logic [ROOT_W-1:0] sq_root;
	r2q_side_t sq_side;

	r2q_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(fr_valid), .rad(fr_rad),
		.side_in(fr_side), .out_valid(sq_valid), .root(sq_root), .side_out(sq_side)
	);

	// setup: magnitudes and scaled numerators for the divider lanes
	logic valid_s3;
	r2q_meta_t meta, meta_s3;
	logic [NUM_W-1:0] num [0:3];
	logic [NUM_W-1:0] num_s3 [0:3];
	logic [DEN_W-1:0] den_s3;

	always_comb begin
		logic [DIF_W-1:0] dv, mag;
		meta.slot = sq_side.slot;
		meta.flag = sq_side.flag;
		meta.zero = (sq_root == '0);
		meta.hq = ROOT_W'(((ROOT_W+1)'(sq_root) + (ROOT_W+1)'(1)) >> 1);
		for (int l = 0; l < 4; l++) begin
			dv = sq_side.d[l];
			mag = dv[DIF_W-1] ? (~dv + DIF_W'(1)) : dv;
			meta.neg[l] = dv[DIF_W-1];
			num[l] = (NUM_W'(mag) << FRAC_BITS) + NUM_W'(sq_root);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else
			valid_s3 <= sq_valid;
	end

	always_ff @(posedge clk) begin
		meta_s3 <= meta;
		den_s3 <= {sq_root, 1'b0};
		for (int l = 0; l < 4; l++)
			num_s3[l] <= num[l];
	end

	logic [QUO_W-1:0] quo [0:3];
	logic ovf [0:3];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		r2q_div u_div (
			.clk(clk), .num(num_s3[l]), .den(den_s3), .quo(quo[l]), .ovf(ovf[l])
		);
	end

	// side information follows the divider lanes
	logic dl_vld [1:QUO_W+1];
	r2q_meta_t dl_meta [1:QUO_W+1];

	for (genvar k = 1; k <= QUO_W + 1; k++) begin : g_delay
		logic p_vld;
		r2q_meta_t p_meta;
		if (k == 1) begin : g_first
			assign p_vld = valid_s3;
			assign p_meta = meta_s3;
		end else begin : g_next
			assign p_vld = dl_vld[k-1];
			assign p_meta = dl_meta[k-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dl_vld[k] <= 1'b0;
			else
				dl_vld[k] <= p_vld;
		end
		always_ff @(posedge clk)
			dl_meta[k] <= p_meta;
	end

	r2q_meta_t fm;
	logic [DATA_WIDTH-1:0] res [0:3];
	logic any_sat;

	assign fm = dl_meta[QUO_W+1];

	always_comb begin
		logic [MAG_W-1:0] m;
		logic ng, big;
		any_sat = 1'b0;
		for (int l = 0; l < 4; l++) begin
			ng = 1'b0;
			big = 1'b0;
			if (fm.slot == r2q_slot_t'(2'(l))) begin
				m = MAG_W'(fm.hq);
			end else if (fm.zero) begin
				m = '0;
			end else begin
				m = MAG_W'(quo[l]);
				ng = fm.neg[l];
				big = ovf[l];
			end
			if (ng) begin
				if (big || m > MAG_NEG) begin
					res[l] = MAG_NEG[DATA_WIDTH-1:0];
					any_sat = 1'b1;
				end else begin
					res[l] = ~m[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
				end
			end else begin
				if (big || m > MAG_POS) begin
					res[l] = MAG_POS[DATA_WIDTH-1:0];
					any_sat = 1'b1;
				end else begin
					res[l] = m[DATA_WIDTH-1:0];
				end
			end
		end
	end

	logic zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dl_vld[QUO_W+1];
	end

	always_ff @(posedge clk) begin
		qw <= res[0];
		qx <= res[1];
		qy <= res[2];
		qz <= res[3];
		clamped <= fm.flag | any_sat;
		zero_q <= fm.zero;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request did not complete after the pipeline latency");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching request");

	a_zero_root: assert property (@(posedge clk) disable iff (!arst_n)
		(done && zero_q) |-> (qw == '0 && qx == '0 && qy == '0 && qz == '0))
		else $error("zero root gave a non-zero component");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");

endmodule

// ===== verif/rotation_matrix_to_quaternion_top_test.sv =====
`timescale 1ns / 100ps

module rotation_matrix_to_quaternion_top_test;
	import r2q_pkg::*;

	typedef logic signed [DATA_WIDTH-1:0] fix_t;

	typedef struct {
		fix_t m [3][3];
	} matrix_t;

	typedef struct {
		fix_t w, x, y, z;
		logic clamped;
	} quat_t;

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	fix_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic done;
	fix_t qw, qx, qy, qz;
	logic clamped;

	matrix_t pending_matrices[$];
	quat_t expected_quats[$];
	int errors = 0;
	int results_seen = 0;
	int requests_sent = 0;
	int clamp_count = 0;
	int cycle_count = 0;
	bit stimulus_done = 0;
	bit hold_off = 0;
	int burst_left = 0;
	int gap_left = 0;

	rotation_matrix_to_quaternion_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.done(done), .qw(qw), .qx(qx), .qy(qy), .qz(qz), .clamped(clamped)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// rounds half away from zero, sign follows the difference
	function automatic longint over_two_root(longint d, longint unsigned s);
		longint unsigned mag;
		longint unsigned quo;
		mag = (d < 0) ? longint'(-d) : longint'(d);
		quo = ((mag << FRAC_BITS) + s) / (2 * s);
		return (d < 0) ? -longint'(quo) : longint'(quo);
	endfunction

	function automatic fix_t saturate(longint v, ref logic flag);
		longint hi;
		longint lo;
		hi = (longint'(1) << (DATA_WIDTH - 1)) - 1;
		lo = -(longint'(1) << (DATA_WIDTH - 1));
		if (v > hi) begin
			v = hi;
			flag = 1'b1;
		end
		if (v < lo) begin
			v = lo;
			flag = 1'b1;
		end
		return fix_t'(v);
	endfunction

	function automatic quat_t matrix_to_quat(matrix_t mat);
		longint a [3][3];
		longint q [4];
		longint one;
		longint tr;
		longint arg;
		longint unsigned s;
		logic flag;
		int i, j, k;
		quat_t res;
		one = longint'(1) << FRAC_BITS;
		flag = 1'b0;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				a[r][c] = mat.m[r][c];
		tr = a[0][0] + a[1][1] + a[2][2];
		if (tr > 0) begin
			arg = tr + one;
			s = int_sqrt(longint'(arg) << FRAC_BITS);
			q[3] = (s + 1) >> 1;
			q[0] = over_two_root(a[2][1] - a[1][2], s);
			q[1] = over_two_root(a[0][2] - a[2][0], s);
			q[2] = over_two_root(a[1][0] - a[0][1], s);
		end else begin
			i = 0;
			if (a[1][1] > a[0][0]) i = 1;
			if (a[2][2] > a[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			arg = (a[i][i] - (a[j][j] + a[k][k])) + one;
			if (arg < 0) begin
				arg = 0;
				flag = 1'b1;
			end
			s = int_sqrt(longint'(arg) << FRAC_BITS);
			q[i] = (s + 1) >> 1;
			if (s != 0) begin
				q[3] = over_two_root(a[k][j] - a[j][k], s);
				q[j] = over_two_root(a[j][i] + a[i][j], s);
				q[k] = over_two_root(a[k][i] + a[i][k], s);
			end else begin
				q[3] = 0;
				q[j] = 0;
				q[k] = 0;
			end
		end
		res.w = saturate(q[3], flag);
		res.x = saturate(q[0], flag);
		res.y = saturate(q[1], flag);
		res.z = saturate(q[2], flag);
		res.clamped = flag;
		return res;
	endfunction

	function automatic fix_t any_entry();
		case ($urandom_range(0, 5))
			0: return fix_t'(16'sh7fff);
			1: return fix_t'(16'sh8000);
			2: return fix_t'(0);
			default: return fix_t'($urandom);
		endcase
	endfunction

	// perturbation of a rotation: random axis permutation with signs, plus noise
	function automatic matrix_t near_rotation();
		matrix_t mat;
		int p [3];
		int t;
		int sgn;
		int noise;
		p = '{0, 1, 2};
		for (int n = 2; n > 0; n--) begin
			t = $urandom_range(0, n);
			{p[n], p[t]} = {p[t], p[n]};
		end
		noise = 1 << $urandom_range(0, 14);
		for (int r = 0; r < 3; r++) begin
			sgn = $urandom_range(0, 1) ? 1 : -1;
			for (int c = 0; c < 3; c++) begin
				t = int'($urandom_range(0, 2 * noise)) - noise;
				if (c == p[r]) t += sgn * 16384;
				if (t > 32767) t = 32767;
				if (t < -32768) t = -32768;
				mat.m[r][c] = fix_t'(t);
			end
		end
		return mat;
	endfunction

	task automatic push_matrix(matrix_t mat);
		pending_matrices.push_back(mat);
	endtask

	task automatic push_diag(int d0, int d1, int d2, int off);
		matrix_t mat;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				mat.m[r][c] = fix_t'(off * (r * 3 + c + 1));
		mat.m[0][0] = fix_t'(d0);
		mat.m[1][1] = fix_t'(d1);
		mat.m[2][2] = fix_t'(d2);
		push_matrix(mat);
	endtask

	task automatic push_fill(int v);
		matrix_t mat;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				mat.m[r][c] = fix_t'(v);
		push_matrix(mat);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			{m00, m01, m02, m10, m11, m12, m20, m21, m22} <= '0;
		end else begin
			matrix_t mat;
			if (start && !busy) begin
				expected_quats.push_back(matrix_to_quat(pending_matrices.pop_front()));
				requests_sent++;
			end
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_matrices.size() == 0 || hold_off) begin
				start <= 1'b0;
			end else begin
				mat = pending_matrices[0];
				{m00, m01, m02} <= {mat.m[0][0], mat.m[0][1], mat.m[0][2]};
				{m10, m11, m12} <= {mat.m[1][0], mat.m[1][1], mat.m[1][2]};
				{m20, m21, m22} <= {mat.m[2][0], mat.m[2][1], mat.m[2][2]};
				start <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		quat_t exp_q;
		if (arst_n) begin
			cycle_count++;
			if (done) begin
				results_seen++;
				if (clamped) clamp_count++;
				if (expected_quats.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					exp_q = expected_quats.pop_front();
					if (qw !== exp_q.w) begin
						$error("qw expected %0d actual %0d", exp_q.w, qw);
						errors++;
					end
					if (qx !== exp_q.x) begin
						$error("qx expected %0d actual %0d", exp_q.x, qx);
						errors++;
					end
					if (qy !== exp_q.y) begin
						$error("qy expected %0d actual %0d", exp_q.y, qy);
						errors++;
					end
					if (qz !== exp_q.z) begin
						$error("qz expected %0d actual %0d", exp_q.z, qz);
						errors++;
					end
					if (clamped !== exp_q.clamped) begin
						$error("clamped expected %0b actual %0b", exp_q.clamped, clamped);
						errors++;
					end
				end
			end
			if (cycle_count > CYCLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		matrix_t mat;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b0;
		@(negedge clk);
		arst_n = 1'b1;

		// directed: identity, half-turns about each axis, diagonal ties, extremes
		push_diag(16384, 16384, 16384, 0);
		push_diag(16384, -16384, -16384, 0);
		push_diag(-16384, 16384, -16384, 0);
		push_diag(-16384, -16384, 16384, 0);
		push_diag(-16384, -16384, -16384, 0);
		push_diag(0, 0, 0, 0);
		push_diag(-5, -5, -5, 100);
		push_diag(-32768, -32768, -32768, 0);
		push_diag(32767, 32767, 32767, 0);
		push_diag(32767, -32768, -32768, 3);
		push_diag(-32768, 32767, 32767, -7);
		push_diag(1, 0, -1, 1);
		push_diag(1, 0, 0, 4000);
		push_diag(-16384, 0, 0, -32768 / 9);
		push_fill(32767);
		push_fill(-32768);
		push_fill(-1);
		push_diag(-32768, -32768, 32767, 1000);
		push_diag(-30000, 20000, 20000, -3000);
		for (int n = 0; n < 4; n++) push_matrix(near_rotation());

		// random: mostly near-rotations, the rest raw values
		for (int n = 0; n < 830; n++) begin
			if ($urandom_range(0, 9) < 6) begin
				mat = near_rotation();
			end else begin
				for (int r = 0; r < 3; r++)
					for (int c = 0; c < 3; c++)
						mat.m[r][c] = any_entry();
			end
			push_matrix(mat);
			// let the pipeline drain completely once mid-run
			if (n == 400) begin
				wait (pending_matrices.size() == 0);
				hold_off = 1;
				wait (expected_quats.size() == 0);
				@(posedge clk);
				hold_off = 0;
			end
		end
		stimulus_done = 1;

		wait (stimulus_done && pending_matrices.size() == 0 && !start);
		wait (expected_quats.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);

		$display("sent %0d matrices, checked %0d quaternions, %0d flagged as clamped",
			requests_sent, results_seen, clamp_count);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== rotation_matrix_to_quaternion_top.f =====
hw/rtl/r2q_pkg.sv
hw/rtl/r2q_front.sv
hw/rtl/r2q_sqrt.sv
hw/rtl/r2q_div.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
verif/rotation_matrix_to_quaternion_top_test.sv
